// ===== rtl/core/pscs_pkg.sv =====
// ----------------------------------------------------------------------------
// pscs_pkg
// shared types and constants of the purge / short-circuit sequencer
// ----------------------------------------------------------------------------
package pscs_pkg;

    localparam int unsigned TS_W       = 32;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALVE_OPEN      = 3'd0,
        CFG_VALVE_TO_PULSE  = 3'd1,
        CFG_PULSE_LENGTH    = 3'd2,
        CFG_PULSE_TO_VALVE  = 3'd3,
        CFG_RACE_MODE       = 3'd4
    } t_cfg_idx;

    // reset values of the timing registers, ms
    localparam logic [TIME_W-1:0] RST_VALVE_OPEN_MS     = 16'd500;
    localparam logic [TIME_W-1:0] RST_VALVE_TO_PULSE_MS = 16'd5000;
    localparam logic [TIME_W-1:0] RST_PULSE_LENGTH_MS   = 16'd100;
    localparam logic [TIME_W-1:0] RST_PULSE_TO_VALVE_MS = 16'd5000;

    typedef struct packed {
        logic [TIME_W-1:0] valve_open_ms;
        logic [TIME_W-1:0] valve_to_pulse_wait_ms;
        logic [TIME_W-1:0] pulse_length_ms;
        logic [TIME_W-1:0] pulse_to_valve_wait_ms;
        logic              race_mode;
    } t_cfg;

    // result of one step, held until the next step
    typedef struct packed {
        logic               valve_open;
        logic               short_active;
        logic               drive_enabled;
        logic [PHASE_W-1:0] phase;
    } t_seq_out;

endpackage

// ===== rtl/core/pscs_cfg.sv =====
// ----------------------------------------------------------------------------
// pscs_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module pscs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pscs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pscs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output pscs_pkg::t_cfg                   o_cfg
);
    import pscs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valve_open_ms          <= RST_VALVE_OPEN_MS;
            r_cfg.valve_to_pulse_wait_ms <= RST_VALVE_TO_PULSE_MS;
            r_cfg.pulse_length_ms        <= RST_PULSE_LENGTH_MS;
            r_cfg.pulse_to_valve_wait_ms <= RST_PULSE_TO_VALVE_MS;
            r_cfg.race_mode              <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VALVE_OPEN:     r_cfg.valve_open_ms          <= i_cfg_wdata;
                CFG_VALVE_TO_PULSE: r_cfg.valve_to_pulse_wait_ms <= i_cfg_wdata;
                CFG_PULSE_LENGTH:   r_cfg.pulse_length_ms        <= i_cfg_wdata;
                CFG_PULSE_TO_VALVE: r_cfg.pulse_to_valve_wait_ms <= i_cfg_wdata;
                CFG_RACE_MODE:      r_cfg.race_mode              <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/pscs_seq.sv =====
// ----------------------------------------------------------------------------
// pscs_seq
// six-phase sequencer: one step per advance, state doubles as result register
// ----------------------------------------------------------------------------
module pscs_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [pscs_pkg::TS_W-1:0]   i_now_ms,
    input  pscs_pkg::t_cfg              i_cfg,
    output pscs_pkg::t_seq_out          o_result
);
    import pscs_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_OPEN        = 3'd0,
        PH_OPEN_WAIT   = 3'd1,
        PH_CLOSED_WAIT = 3'd2,
        PH_PULSE_START = 3'd3,
        PH_PULSE       = 3'd4,
        PH_PULSE_WAIT  = 3'd5
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [TS_W-1:0]   r_start, n_start;
    logic              r_valve, n_valve;
    logic              r_short, n_short;
    logic              r_drive, n_drive;

    logic [TS_W-1:0]   elapsed;
    logic [TIME_W-1:0] limit;
    logic              expired;

    // wrapping elapsed time against the limit of the current phase
    always_comb begin
        case (r_phase)
            PH_OPEN_WAIT:   limit = i_cfg.valve_open_ms;
            PH_CLOSED_WAIT: limit = i_cfg.valve_to_pulse_wait_ms;
            PH_PULSE:       limit = i_cfg.pulse_length_ms;
            PH_PULSE_WAIT:  limit = i_cfg.pulse_to_valve_wait_ms;
            default:        limit = '0;
        endcase
    end

    assign elapsed = i_now_ms - r_start;
    assign expired = elapsed > {{(TS_W-TIME_W){1'b0}}, limit};

    // a phase that restarts its timer cannot expire in the same step,
    // so at most the wait-to-pulse chain passes two phases at once
    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_valve = r_valve;
        n_short = r_short;
        n_drive = r_drive;
        case (r_phase)
            PH_OPEN_WAIT: begin
                if (expired) begin
                    n_valve = 1'b0;
                    n_start = i_now_ms;
                    n_phase = PH_CLOSED_WAIT;
                end
            end
            PH_CLOSED_WAIT: begin
                if (expired) begin
                    if (!i_cfg.race_mode) begin
                        n_drive = 1'b0;
                        n_short = 1'b1;
                    end
                    n_start = i_now_ms;
                    n_phase = PH_PULSE;
                end
            end
            PH_PULSE_START: begin
                if (!i_cfg.race_mode) begin
                    n_drive = 1'b0;
                    n_short = 1'b1;
                end
                n_start = i_now_ms;
                n_phase = PH_PULSE;
            end
            PH_PULSE: begin
                if (expired) begin
                    if (!i_cfg.race_mode) begin
                        n_short = 1'b0;
                        n_drive = 1'b1;
                    end
                    n_start = i_now_ms;
                    n_phase = PH_PULSE_WAIT;
                end
            end
            PH_PULSE_WAIT: begin
                if (expired) begin
                    n_phase = PH_OPEN;
                end
            end
            default: begin
                // open phase, and unused codes treated alike
                n_valve = 1'b1;
                n_start = i_now_ms;
                n_phase = PH_OPEN_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_start <= '0;
            r_valve <= 1'b0;
            r_short <= 1'b0;
            r_drive <= 1'b1;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_valve <= n_valve;
            r_short <= n_short;
            r_drive <= n_drive;
        end
    end

    assign o_result.valve_open    = r_valve;
    assign o_result.short_active  = r_short;
    assign o_result.drive_enabled = r_drive;
    assign o_result.phase         = r_phase;

    a_valve_only_in_open_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valve == (r_phase == PH_OPEN_WAIT))
        else $error("valve state disagrees with phase");

    a_short_implies_drive_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_short |-> !r_drive)
        else $error("short-circuit closed with drive enabled");

    a_pulse_start_transient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_PULSE_START)
        else $error("pulse start phase held across a step");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_start) && $stable(r_phase))
        else $error("sequencer state moved without a step");

endmodule

// ===== rtl/core/purge_short_circuit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// purge_short_circuit_sequencer_top
// purge valve and short-circuit switch sequencer with request pipeline
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  input    | i_in_valid / o_in_stall    | i_now_ms
//  result   | o_out_valid / i_out_stall  | o_valve_open o_short_active
//           |                            | o_drive_enabled o_phase
//  config   | i_cfg_we                   | i_cfg_idx i_cfg_wdata
//
//  one request per cycle sustained unless the result stalls; a request passes
//  the input register, then one step of the sequencer into the result register.
//  the step is a single wrapping subtract and compare on the timestamp.
//  synchronous active-low reset empties both registers and puts the sequencer
//  in its open phase with the drive enabled. a stalled result holds the
//  sequencer; one further request waits in the input register.
// ----------------------------------------------------------------------------
module purge_short_circuit_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input requests
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [pscs_pkg::TS_W-1:0]        i_now_ms,
    // results
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_valve_open,
    output logic                             o_short_active,
    output logic                             o_drive_enabled,
    output logic [pscs_pkg::PHASE_W-1:0]     o_phase,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [pscs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pscs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pscs_pkg::*;

    t_cfg            cfg;
    t_seq_out        result;

    logic            r_in_valid, n_in_valid;
    logic [TS_W-1:0] r_now;
    logic            r_out_valid, n_out_valid;

    logic            out_free;   // result register can take a new step
    logic            advance;    // sequencer steps on the held request
    logic            in_take;    // new request enters the input register
    logic            out_take;   // result leaves

    pscs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // result register is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // timestamp payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= i_now_ms;
        end
    end

    // sequencer state is also the result register
    pscs_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_now_ms  (r_now),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_valve_open    = result.valve_open;
    assign o_short_active  = result.short_active;
    assign o_drive_enabled = result.drive_enabled;
    assign o_phase         = result.phase;

    a_step_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("step taken but no result presented");

    a_held_request_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_now))
        else $error("held request lost while result stalled");

    a_no_step_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !advance)
        else $error("sequencer stepped over a stalled result");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the purge valve / short-circuit sequencer
//
// a tracker object follows the six-phase cycle request by request and keeps
// the outputs each request must produce. a short directed run covers the
// boundary of every wait, timestamp wrap, zero and full-scale times and race
// mode flipped while the switch is closed. random timestamps follow, partly
// aimed at the wait boundaries, under shifting timing and race settings and
// three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pscs_pkg::*;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_VALVE_ARM  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_VALVE_HOLD = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SETTLE     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SHORT_ARM  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SHORT_HOLD = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RECOVER    = 3'd5;

    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned BLOCKS       = 5;
    localparam int unsigned BLOCK_ITEMS  = 50;
    localparam int unsigned DRAIN_CYCLES = 8;

    // follows the sequencer state and queues the outputs owed per request
    class purge_cycle_tracker;
        t_cfg               cfg;
        logic [PHASE_W-1:0] ph;
        logic [TS_W-1:0]    phase_start;
        logic               valve;
        logic               short_on;
        logic               drive_on;
        t_seq_out           due_outputs[$];
        int unsigned        n_requests;
        int unsigned        n_results;
        int unsigned        n_rounds;
        int unsigned        n_pulses;
        int unsigned        n_errors;

        function new();
            cfg.valve_open_ms          = RST_VALVE_OPEN_MS;
            cfg.valve_to_pulse_wait_ms = RST_VALVE_TO_PULSE_MS;
            cfg.pulse_length_ms        = RST_PULSE_LENGTH_MS;
            cfg.pulse_to_valve_wait_ms = RST_PULSE_TO_VALVE_MS;
            cfg.race_mode              = 1'b0;
            ph          = PH_VALVE_ARM;
            phase_start = '0;
            valve       = 1'b0;
            short_on    = 1'b0;
            drive_on    = 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_VALVE_OPEN:     cfg.valve_open_ms          = data;
                CFG_VALVE_TO_PULSE: cfg.valve_to_pulse_wait_ms = data;
                CFG_PULSE_LENGTH:   cfg.pulse_length_ms        = data;
                CFG_PULSE_TO_VALVE: cfg.pulse_to_valve_wait_ms = data;
                CFG_RACE_MODE:      cfg.race_mode              = data[0];
                default: ;
            endcase
        endfunction

        // wrapping elapsed time, strictly past the limit
        function bit expired(logic [TS_W-1:0] now, logic [TIME_W-1:0] lim);
            logic [TS_W-1:0] gap;
            gap = now - phase_start;
            return gap > TS_W'(lim);
        endfunction

        // every phase is tried in order, so one stamp can pass several
        function t_seq_out advance_sequence(logic [TS_W-1:0] now);
            t_seq_out res;
            if (ph > PH_RECOVER)
                ph = PH_VALVE_ARM;
            if (ph == PH_VALVE_ARM) begin
                valve       = 1'b1;
                phase_start = now;
                ph          = PH_VALVE_HOLD;
            end
            if (ph == PH_VALVE_HOLD && expired(now, cfg.valve_open_ms)) begin
                valve       = 1'b0;
                phase_start = now;
                ph          = PH_SETTLE;
            end
            if (ph == PH_SETTLE && expired(now, cfg.valve_to_pulse_wait_ms))
                ph = PH_SHORT_ARM;
            if (ph == PH_SHORT_ARM) begin
                if (!cfg.race_mode) begin
                    drive_on = 1'b0;
                    short_on = 1'b1;
                    n_pulses++;
                end
                phase_start = now;
                ph          = PH_SHORT_HOLD;
            end
            if (ph == PH_SHORT_HOLD && expired(now, cfg.pulse_length_ms)) begin
                if (!cfg.race_mode) begin
                    short_on = 1'b0;
                    drive_on = 1'b1;
                end
                phase_start = now;
                ph          = PH_RECOVER;
            end
            if (ph == PH_RECOVER && expired(now, cfg.pulse_to_valve_wait_ms)) begin
                ph = PH_VALVE_ARM;
                n_rounds++;
            end
            res.valve_open    = valve;
            res.short_active  = short_on;
            res.drive_enabled = drive_on;
            res.phase         = ph;
            return res;
        endfunction

        function void note_request(logic [TS_W-1:0] now);
            n_requests++;
            due_outputs.push_back(advance_sequence(now));
        endfunction

        function void check_result(t_seq_out got);
            t_seq_out want;
            if (due_outputs.size() == 0) begin
                $error("result with nothing pending: valve_open %0d short_active %0d drive_enabled %0d phase %0d",
                       got.valve_open, got.short_active, got.drive_enabled, got.phase);
                n_errors++;
                return;
            end
            want = due_outputs.pop_front();
            n_results++;
            if (got.valve_open !== want.valve_open) begin
                $error("valve_open: expected %0d, actual %0d", want.valve_open, got.valve_open);
                n_errors++;
            end
            if (got.short_active !== want.short_active) begin
                $error("short_active: expected %0d, actual %0d", want.short_active, got.short_active);
                n_errors++;
            end
            if (got.drive_enabled !== want.drive_enabled) begin
                $error("drive_enabled: expected %0d, actual %0d", want.drive_enabled, got.drive_enabled);
                n_errors++;
            end
            if (got.phase !== want.phase) begin
                $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                n_errors++;
            end
        endfunction

        function int unsigned pending();
            return due_outputs.size();
        endfunction
    endclass

    // every input known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [TS_W-1:0]       i_now_ms    = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_VALVE_OPEN;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_valve_open;
    logic                  o_short_active;
    logic                  o_drive_enabled;
    logic [PHASE_W-1:0]    o_phase;

    purge_cycle_tracker    sb = new();
    logic [TS_W-1:0]       last_stamp   = '0;
    int unsigned           tx_idle_pct  = 0;
    int unsigned           rx_idle_pct  = 0;
    int unsigned           n_cfg_writes = 0;
    int unsigned           cycle_cnt    = 0;

    purge_short_circuit_sequencer_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_valve_open    (o_valve_open),
        .o_short_active  (o_short_active),
        .o_drive_enabled (o_drive_enabled),
        .o_phase         (o_phase),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_cnt, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side stalls at random, changed on the falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // results are taken on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(t_seq_out'({o_valve_open, o_short_active,
                                        o_drive_enabled, o_phase}));
    end

    // one request: optional idle cycles, then hold until taken
    task automatic send_request(input logic [TS_W-1:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms   <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(stamp);
        last_stamp = stamp;
    endtask

    // registers change only once the block has nothing in flight
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // race bit in bit 0, the upper bits are noise the block must mask
    task automatic program_race(input bit race);
        logic [CFG_DATA_W-1:0] data;
        data    = CFG_DATA_W'($urandom);
        data[0] = race;
        program_reg(CFG_RACE_MODE, data);
    endtask

    // mostly short times so cycles turn over quickly, sometimes the extremes
    task automatic shuffle_timing();
        int unsigned r;
        for (int k = CFG_VALVE_OPEN; k <= CFG_PULSE_TO_VALVE; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                program_reg(CFG_IDX_W'(k), '0);
            else if (r < 16)
                program_reg(CFG_IDX_W'(k), '1);
            else if (r < 24)
                program_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
            else
                program_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 48)));
        end
        program_race($urandom_range(0, 99) < 30);
        // unused indexes must leave everything alone
        if ($urandom_range(0, 99) < 25)
            program_reg(CFG_IDX_W'($urandom_range(CFG_RACE_MODE + 1, (1 << CFG_IDX_W) - 1)),
                        CFG_DATA_W'($urandom));
    endtask

    // next timestamp: aimed at the wait in progress, creeping, or jumping
    function automatic logic [TS_W-1:0] next_stamp();
        logic [TIME_W-1:0] lim;
        int unsigned       r;
        case (sb.ph)
            PH_VALVE_HOLD: lim = sb.cfg.valve_open_ms;
            PH_SETTLE:     lim = sb.cfg.valve_to_pulse_wait_ms;
            PH_SHORT_HOLD: lim = sb.cfg.pulse_length_ms;
            PH_RECOVER:    lim = sb.cfg.pulse_to_valve_wait_ms;
            default:       lim = '0;
        endcase
        r = $urandom_range(0, 99);
        if (r < 35)
            return sb.phase_start + TS_W'(lim) + $urandom_range(0, 1);
        else if (r < 80)
            return last_stamp + $urandom_range(0, 40);
        else if (r < 92)
            return last_stamp + $urandom;
        else
            return $urandom;
    endfunction

    initial begin
        // reset held from time zero, released away from the rising edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: reset timing ----
        send_request('0);                                     // valve opens at time zero
        send_request(TS_W'(RST_VALVE_OPEN_MS));               // open time reached, not passed
        send_request(TS_W'(RST_VALVE_OPEN_MS) + 1);           // valve closes
        send_request(sb.phase_start + RST_VALVE_TO_PULSE_MS); // settle wait exactly met
        send_request('1);                                     // all-ones stamp starts the pulse
        send_request(TS_W'(RST_PULSE_LENGTH_MS) - 1);         // wrapped, pulse length exactly met
        send_request(TS_W'(RST_PULSE_LENGTH_MS));             // pulse ends across the wrap
        send_request(sb.phase_start + RST_PULSE_TO_VALVE_MS);
        send_request(sb.phase_start + RST_PULSE_TO_VALVE_MS + 1); // back to the open phase
        send_request(last_stamp);                             // valve reopens

        // ---- directed: zero and full-scale times, race mode mid-pulse ----
        program_reg(CFG_VALVE_OPEN, '0);
        program_reg(CFG_VALVE_TO_PULSE, '0);
        program_reg(CFG_PULSE_LENGTH, '1);
        program_reg(CFG_PULSE_TO_VALVE, '1);
        send_request(last_stamp);                    // zero elapsed never exceeds zero
        send_request(last_stamp + 1);                // valve closes
        send_request(last_stamp + 1);                // settle and pulse start in one step
        send_request(sb.phase_start + 32'hffff);     // full-scale pulse still running
        program_race(1'b1);                          // race mode while the switch is closed
        send_request(sb.phase_start + (1 << TIME_W)); // pulse ends, switch left closed
        send_request(sb.phase_start + (1 << TIME_W)); // rest over
        send_request(last_stamp);                    // valve opens, switch still closed
        program_race(1'b0);
        send_request(last_stamp + 1);
        send_request(last_stamp + 1);                // pulse starts again with race off
        send_request(sb.phase_start + (1 << TIME_W)); // switch finally reopens
        program_reg(CFG_IDX_W'(CFG_RACE_MODE + 1), '1); // unused index

        // ---- random: three idling patterns, several settings each ----
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin tx_idle_pct = 7;  rx_idle_pct = 81; end
                1:       begin tx_idle_pct = 81; rx_idle_pct = 7;  end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int blk = 0; blk < BLOCKS; blk++) begin
                shuffle_timing();
                last_stamp = $urandom;
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    // occasional race flip wherever the cycle happens to be
                    if ($urandom_range(0, 99) < 3)
                        program_race(!sb.cfg.race_mode);
                    send_request(next_stamp());
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // let everything come out, then watch for stray results
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results compared, %0d register writes",
                 sb.n_requests, sb.n_results, n_cfg_writes);
        $display("%0d full valve rounds, %0d switch pulses, %0d mismatches",
                 sb.n_rounds, sb.n_pulses, sb.n_errors);
        if (sb.n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pscs_pkg.sv
rtl/core/pscs_cfg.sv
rtl/core/pscs_seq.sv
rtl/core/purge_short_circuit_sequencer_top.sv
sim/tb.sv
